// ----- src/pidc_pkg.sv -----
`default_nettype none

package pidc_pkg;

    // fixed-point format and field widths
    localparam int FRAC_BITS    = 12;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SETPOINT_W   = 16;
    localparam int GAIN_W       = 24;
    localparam int DRIVE_W      = 16;
    localparam int INTEG_W      = 32;
    localparam int ERR_W        = ((SAMPLE_WIDTH > SETPOINT_W) ? SAMPLE_WIDTH : SETPOINT_W) + 1;
    localparam int DIFF_W       = ERR_W + 1;
    localparam int ACC_W        = GAIN_W + ((INTEG_W > DIFF_W) ? INTEG_W : DIFF_W) + 2;
    localparam int SUM_W        = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    // queues between and after the two halves
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // reset values of the clamp limits and integral saturation bounds
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RST = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RST = {1'b1, {(DRIVE_W-1){1'b0}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MAX     = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN     = {1'b1, {(INTEG_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_DRIVE_MAX = 3'd4,
        REG_DRIVE_MIN = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        FUNC_STEP  = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        CLAMP_NONE  = 2'd0,
        CLAMP_UPPER = 2'd1,
        CLAMP_LOWER = 2'd2
    } clamp_t;

    typedef struct packed {
        func_t                          func;
        logic signed [SAMPLE_WIDTH-1:0] measured;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        clamp_t                    clamp_state;
    } out_item_t;

    // classified item passed from front to back
    typedef struct packed {
        logic                    clear;
        logic signed [ERR_W-1:0] err;
    } cmd_t;

    typedef struct packed {
        logic signed [SETPOINT_W-1:0] setpoint;
        logic signed [GAIN_W-1:0]     gain_p;
        logic signed [GAIN_W-1:0]     gain_i;
        logic signed [GAIN_W-1:0]     gain_d;
        logic signed [DRIVE_W-1:0]    drive_max;
        logic signed [DRIVE_W-1:0]    drive_min;
    } cfg_regs_t;

endpackage

`default_nettype wire

// ----- src/pid_controller_antiwindup.sv -----
// PID controller with conditional-integration anti-windup.
// Input channel: present an item on request and raise push; it is taken at
// a rising edge with push high and full low. func selects a control step on
// the measured sample or a clear of the integral and error history.
// Result channel: while empty is low, result holds the oldest item (clamped
// drive and clamp_state); it is taken at a rising edge with pop high.
// Configuration: cfg_index/cfg_data written at an edge with cfg_valid high;
// cfg_ready is always high. Write only while no items are in flight.
// Path: an item taken on request is registered in the command queue, then in
// the result queue, before it shows on result and can be popped.
// Throughput: one item per cycle while the result queue has room or is popped,
// set by the state loop in the back end (three multiplies, sum, clamp and integral update per cycle).
// Stalls: if pop stays low, the two-entry result queue fills, then the
// two-entry command queue, and full rises; up to four items are held.
// Reset: both queues empty, integral and previous error zero, gains and
// setpoint zero, limits at the full signed 16-bit range.

`default_nettype none

module pid_controller_antiwindup (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire pidc_pkg::in_item_t               request,
    output logic                                  empty,
    input  wire logic                             pop,
    output pidc_pkg::out_item_t                   result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pidc_pkg::cfg_regs_t regs;
    pidc_pkg::cmd_t      cmd;
    logic                cmd_valid;
    logic                cmd_take;

    // configuration registers
    pidc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    // accept and classify items
    pidc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .regs      (regs),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // control law, state update and result queue
    pidc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ----- src/pidc_cfg.sv -----
`default_nettype none

module pidc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pidc_pkg::cfg_regs_t                   regs
);

    pidc_pkg::cfg_regs_t regs_reg;
    pidc_pkg::cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    // register write decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            case (pidc_pkg::cfg_reg_t'(cfg_index))
                pidc_pkg::REG_SETPOINT:
                    regs_next.setpoint = cfg_data[pidc_pkg::SETPOINT_W-1:0];
                pidc_pkg::REG_GAIN_P:
                    regs_next.gain_p = cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_GAIN_I:
                    regs_next.gain_i = cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_GAIN_D:
                    regs_next.gain_d = cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_DRIVE_MAX:
                    regs_next.drive_max = cfg_data[pidc_pkg::DRIVE_W-1:0];
                pidc_pkg::REG_DRIVE_MIN:
                    regs_next.drive_min = cfg_data[pidc_pkg::DRIVE_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.setpoint  <= '0;
            regs_reg.gain_p    <= '0;
            regs_reg.gain_i    <= '0;
            regs_reg.gain_d    <= '0;
            regs_reg.drive_max <= pidc_pkg::DRIVE_MAX_RST;
            regs_reg.drive_min <= pidc_pkg::DRIVE_MIN_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pidc_front.sv -----
`default_nettype none

module pidc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire pidc_pkg::in_item_t   request,
    input  wire pidc_pkg::cfg_regs_t  regs,
    output logic                      cmd_valid,
    output pidc_pkg::cmd_t            cmd,
    input  wire logic                 cmd_take
);

    localparam logic [pidc_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
        pidc_pkg::QUEUE_CNT_W'(pidc_pkg::QUEUE_DEPTH);
    localparam logic [pidc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        pidc_pkg::QUEUE_PTR_W'(pidc_pkg::QUEUE_DEPTH - 1);

    pidc_pkg::cmd_t                      mem_reg [pidc_pkg::QUEUE_DEPTH];
    logic [pidc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [pidc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [pidc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [pidc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [pidc_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [pidc_pkg::QUEUE_CNT_W-1:0]    count_next;

    logic                                accept;
    logic signed [pidc_pkg::ERR_W-1:0]   sp_ext;
    logic signed [pidc_pkg::ERR_W-1:0]   meas_ext;
    pidc_pkg::cmd_t                      cmd_new;

    assign full      = (count_reg == DEPTH_CNT);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign accept    = push && !full;

    // classify the item and form the control error
    always_comb
    begin
        sp_ext        = pidc_pkg::ERR_W'($signed(regs.setpoint));
        meas_ext      = pidc_pkg::ERR_W'($signed(request.measured));
        cmd_new.clear = (request.func == pidc_pkg::FUNC_CLEAR);
        cmd_new.err   = sp_ext - meas_ext;
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_take)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !cmd_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && cmd_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

`default_nettype wire

// ----- src/pidc_back.sv -----
`default_nettype none

module pidc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pidc_pkg::cfg_regs_t  regs,
    input  wire logic                 cmd_valid,
    input  wire pidc_pkg::cmd_t       cmd,
    output logic                      cmd_take,
    output logic                      empty,
    input  wire logic                 pop,
    output pidc_pkg::out_item_t       result
);

    localparam logic [pidc_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
        pidc_pkg::QUEUE_CNT_W'(pidc_pkg::QUEUE_DEPTH);
    localparam logic [pidc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        pidc_pkg::QUEUE_PTR_W'(pidc_pkg::QUEUE_DEPTH - 1);

    // controller state
    logic signed [pidc_pkg::INTEG_W-1:0]  integ_reg;
    logic signed [pidc_pkg::INTEG_W-1:0]  integ_next;
    logic signed [pidc_pkg::ERR_W-1:0]    prev_err_reg;
    logic signed [pidc_pkg::ERR_W-1:0]    prev_err_next;

    // result queue
    pidc_pkg::out_item_t                  mem_reg [pidc_pkg::QUEUE_DEPTH];
    logic [pidc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [pidc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [pidc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [pidc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [pidc_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [pidc_pkg::QUEUE_CNT_W-1:0]     count_next;

    logic                                 pop_ok;

    // datapath
    logic signed [pidc_pkg::ERR_W-1:0]              err;
    logic signed [pidc_pkg::GAIN_W-1:0]             gp;
    logic signed [pidc_pkg::GAIN_W-1:0]             gi;
    logic signed [pidc_pkg::GAIN_W-1:0]             gd;
    logic signed [pidc_pkg::DIFF_W-1:0]             diff;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::ERR_W-1:0]   prod_p;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::DIFF_W-1:0]  prod_d;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::INTEG_W-1:0] prod_i;
    logic signed [pidc_pkg::ACC_W-1:0]              acc;
    logic signed [pidc_pkg::ACC_W-1:0]              raw;
    logic signed [pidc_pkg::ACC_W-1:0]              hi_ext;
    logic signed [pidc_pkg::ACC_W-1:0]              lo_ext;
    logic signed [pidc_pkg::SUM_W-1:0]              sum;
    logic [pidc_pkg::SUM_W-pidc_pkg::INTEG_W:0]     sum_top;
    logic signed [pidc_pkg::INTEG_W-1:0]            sum_sat;
    logic                                           update;
    pidc_pkg::out_item_t                            res_new;

    assign pop_ok   = pop && !empty;
    assign empty    = (count_reg == '0);
    assign result   = mem_reg[rd_ptr_reg];
    assign cmd_take = cmd_valid && ((count_reg != DEPTH_CNT) || pop_ok);

    // three products, sum and floor shift
    always_comb
    begin
        err    = cmd.err;
        gp     = regs.gain_p;
        gi     = regs.gain_i;
        gd     = regs.gain_d;
        diff   = pidc_pkg::DIFF_W'(err) - pidc_pkg::DIFF_W'(prev_err_reg);
        prod_p = gp * err;
        prod_d = gd * diff;
        prod_i = gi * integ_reg;
        acc    = ((pidc_pkg::ACC_W'(prod_p) + pidc_pkg::ACC_W'(prod_d)) <<< 1)
               + pidc_pkg::ACC_W'(prod_i);
        raw    = acc >>> (pidc_pkg::FRAC_BITS + 1);
        hi_ext = pidc_pkg::ACC_W'(regs.drive_max);
        lo_ext = pidc_pkg::ACC_W'(regs.drive_min);
    end

    // clamp (a clear gives zero drive), upper limit tested first
    always_comb
    begin
        if (cmd.clear)
        begin
            res_new.drive       = '0;
            res_new.clamp_state = pidc_pkg::CLAMP_NONE;
        end
        else if (raw > hi_ext)
        begin
            res_new.drive       = regs.drive_max;
            res_new.clamp_state = pidc_pkg::CLAMP_UPPER;
        end
        else if (raw < lo_ext)
        begin
            res_new.drive       = regs.drive_min;
            res_new.clamp_state = pidc_pkg::CLAMP_LOWER;
        end
        else
        begin
            res_new.drive       = raw[pidc_pkg::DRIVE_W-1:0];
            res_new.clamp_state = pidc_pkg::CLAMP_NONE;
        end
    end

    // saturating trapezoid integral and conditional update
    always_comb
    begin
        sum = pidc_pkg::SUM_W'(integ_reg) + pidc_pkg::SUM_W'(err)
            + pidc_pkg::SUM_W'(prev_err_reg);
        sum_top = sum[pidc_pkg::SUM_W-1:pidc_pkg::INTEG_W-1];
        if ((&sum_top) || !(|sum_top))
        begin
            sum_sat = sum[pidc_pkg::INTEG_W-1:0];
        end
        else if (sum[pidc_pkg::SUM_W-1])
        begin
            sum_sat = pidc_pkg::INTEG_MIN;
        end
        else
        begin
            sum_sat = pidc_pkg::INTEG_MAX;
        end

        update = (res_new.clamp_state == pidc_pkg::CLAMP_NONE)
              || ((err != '0) && (integ_reg != '0)
                  && (err[pidc_pkg::ERR_W-1] != integ_reg[pidc_pkg::INTEG_W-1]));

        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        if (cmd_take)
        begin
            if (cmd.clear)
            begin
                integ_next    = '0;
                prev_err_next = '0;
            end
            else if (update)
            begin
                integ_next    = sum_sat;
                prev_err_next = err;
            end
        end
    end

    // result queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd_take)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (cmd_take && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!cmd_take && pop_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            mem_reg[wr_ptr_reg] <= res_new;
        end
    end

endmodule

`default_nettype wire
